@@ rtl/sliding_window_min_max_filter_unit_defines.svh @@
// ----------------------------------------------------------------------------
// sliding window min/max filter: assertion macros
// Concurrent assertion helpers clocked on clk with rst_n as disable.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_FILTER_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SWMMF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swmmf: same-cycle check failed");

// next-cycle implication
`define SWMMF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swmmf: next-cycle check failed");

`else

`define SWMMF_ASSERT_IMP(lbl, ante, cons)
`define SWMMF_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ rtl/swmmf_pkg.sv @@
// ----------------------------------------------------------------------------
// swmmf_pkg
// Shared constants, types and helpers of the sliding window min/max filter.
// ----------------------------------------------------------------------------
package swmmf_pkg;

    // pixel and configuration widths
    localparam int PIX_W      = 8;
    localparam int CFG_SIZE_W = 11;
    localparam int ROW_W      = 10;
    localparam int KSIDE_W    = 4;

    // parameter defaults
    localparam int MAX_KERNEL_DEF = 7;
    localparam int MAX_WIDTH_DEF  = 1024;

    // frame height limit
    localparam logic [CFG_SIZE_W-1:0] MAX_HEIGHT = 11'd1024;

    // extreme pixel values, identities of the minimum and the maximum
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

    // register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_RADIUS = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    // per-request flags that travel down the pipeline
    typedef struct packed {
        logic emit;
        logic last;
    } swmmf_flags_t;

    // maximum (dilation) or minimum (erosion) of two pixels
    function automatic logic [PIX_W-1:0] pick_px(
        input logic             minimum,
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b
    );
        logic [PIX_W-1:0] res;
        if (minimum)
        begin
            res = (b < a) ? b : a;
        end
        else
        begin
            res = (b > a) ? b : a;
        end
        return res;
    endfunction

    // start value of a reduction
    function automatic logic [PIX_W-1:0] ident_px(input logic minimum);
        return minimum ? PIX_MAX : PIX_MIN;
    endfunction

endpackage

@@ rtl/sliding_window_min_max_filter_unit.sv @@
// Pipeline: a pixel request accepted by the unit passes stage one, stage two and the
// output register before its result shows at out_valid; pixels whose window is not
// fully inside the frame give no result.
// Throughput: one pixel per cycle while the output register is free, set by the single
// line memory that is read at the pixel's column on accept and written back from stage one.
// Reset: counters and pipeline valids clear and configuration takes its defaults at once;
// the line memory is not cleared, so no start-up sweep is needed.
// ----------------------------------------------------------------------------
// sliding_window_min_max_filter_unit
// Streaming grayscale dilation/erosion over a square window of odd side.
// Older rows live in one line memory (one word per column holding all row
// delays); recent columns are kept raw in a window register, reduced per
// column and then across columns.
// ----------------------------------------------------------------------------
`include "sliding_window_min_max_filter_unit_defines.svh"

module sliding_window_min_max_filter_unit
    import swmmf_pkg::*;
#(
    parameter int MAX_KERNEL = MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration port
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_SIZE_W-1:0] cfg_data,
    // pixel channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      pixel,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      value,
    output logic                  frame_end
);

    localparam int LINES = MAX_KERNEL - 1;
    localparam int SLOTS = (LINES > 0) ? LINES : 1;
    localparam int MEM_W = SLOTS * PIX_W;
    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SZ_W  = (CW + 1 > CFG_SIZE_W) ? CW + 1 : CFG_SIZE_W;
    localparam logic [SZ_W-1:0]    MAX_W_SZ = SZ_W'(MAX_WIDTH);
    localparam logic [KSIDE_W-1:0] K_TOP    =
        KSIDE_W'((MAX_KERNEL % 2 == 1) ? MAX_KERNEL : MAX_KERNEL - 1);

    // configuration registers
    logic                  mode_reg;
    logic [1:0]            radius_reg;
    logic [CFG_SIZE_W-1:0] width_reg;
    logic [CFG_SIZE_W-1:0] height_reg;

    // position counters
    logic [CW-1:0]    col_reg,  col_next;
    logic [ROW_W-1:0] row_reg,  row_next;

    // pipeline control
    logic             pipe_en;
    logic             accept;
    logic             s1_valid_reg;
    logic             s2_valid_reg;
    logic             out_valid_reg;
    swmmf_flags_t     flags_next;
    swmmf_flags_t     s1_flags_reg;
    swmmf_flags_t     s2_flags_reg;

    // pipeline payload
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [PIX_W-1:0] value_reg;
    logic             frame_end_reg;

    // line memory and forwarding
    logic [MEM_W-1:0] line_mem [MAX_WIDTH];
    logic [MEM_W-1:0] rd_data_reg;
    logic             fwd_valid_reg;
    logic [CW-1:0]    fwd_col_reg;
    logic [MEM_W-1:0] fwd_data_reg;
    logic             fwd_hit;
    logic [MEM_W-1:0] line_old;
    logic [MEM_W-1:0] wr_data;
    logic             wr_en;

    // window reduction
    logic [PIX_W-1:0] col_px [MAX_KERNEL];
    logic [PIX_W-1:0] win_reg [SLOTS][MAX_KERNEL];
    logic [PIX_W-1:0] win_px [MAX_KERNEL][MAX_KERNEL];
    logic [PIX_W-1:0] col_acc [MAX_KERNEL];
    logic [PIX_W-1:0] colred_reg [MAX_KERNEL];
    logic [PIX_W-1:0] win_acc;

    // effective sizes
    logic [SZ_W-1:0]       width_ext;
    logic [SZ_W-1:0]       w_eff;
    logic [CFG_SIZE_W-1:0] h_eff;
    logic [KSIDE_W-1:0]    k_raw;
    logic [KSIDE_W-1:0]    k_side;

    // position of the current request
    logic [CW-1:0]         c0;
    logic [ROW_W-1:0]      r0;
    logic [CFG_SIZE_W-1:0] r_pre;
    logic [CFG_SIZE_W-1:0] r_inc;
    logic [SZ_W-1:0]       c_inc;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            radius_reg <= 2'd1;
            width_reg  <= 11'd640;
            height_reg <= 11'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[0];
                REG_RADIUS: radius_reg <= cfg_data[1:0];
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    // clamp frame size and kernel side
    always_comb
    begin
        width_ext = SZ_W'(width_reg);
        if (width_reg == '0)
        begin
            w_eff = SZ_W'(1);
        end
        else if (width_ext > MAX_W_SZ)
        begin
            w_eff = MAX_W_SZ;
        end
        else
        begin
            w_eff = width_ext;
        end

        if (height_reg == '0)
        begin
            h_eff = CFG_SIZE_W'(1);
        end
        else if (height_reg > MAX_HEIGHT)
        begin
            h_eff = MAX_HEIGHT;
        end
        else
        begin
            h_eff = height_reg;
        end

        k_raw  = KSIDE_W'({radius_reg, 1'b1});
        k_side = (k_raw > K_TOP) ? K_TOP : k_raw;
    end

    // position of this pixel, border test and next position
    always_comb
    begin
        if (SZ_W'(col_reg) >= w_eff)
        begin
            c0    = '0;
            r_pre = CFG_SIZE_W'(row_reg) + CFG_SIZE_W'(1);
        end
        else
        begin
            c0    = col_reg;
            r_pre = CFG_SIZE_W'(row_reg);
        end
        r0 = (r_pre >= h_eff) ? '0 : r_pre[ROW_W-1:0];

        flags_next.emit = (CFG_SIZE_W'(r0) + CFG_SIZE_W'(1) >= CFG_SIZE_W'(k_side))
                       && (SZ_W'(c0) + SZ_W'(1) >= SZ_W'(k_side));
        flags_next.last = (CFG_SIZE_W'(r0) == h_eff - CFG_SIZE_W'(1))
                       && (SZ_W'(c0) == w_eff - SZ_W'(1));

        c_inc = SZ_W'(c0) + SZ_W'(1);
        r_inc = CFG_SIZE_W'(r0) + CFG_SIZE_W'(1);
        if (c_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = c_inc[CW-1:0];
            row_next = r0;
        end
    end

    // handshake: the whole pipe moves when the output register is free
    assign pipe_en  = !out_valid_reg || out_ready;
    assign in_ready = pipe_en;
    assign accept   = in_valid && pipe_en;
    assign wr_en    = s1_valid_reg && pipe_en;

    // counters and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            s1_flags_reg  <= '0;
            s2_flags_reg  <= '0;
        end
        else if (pipe_en)
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg  <= accept;
            s1_flags_reg  <= flags_next;
            s2_valid_reg  <= s1_valid_reg;
            s2_flags_reg  <= s1_flags_reg;
            out_valid_reg <= s2_valid_reg && s2_flags_reg.emit;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    // line memory: read at accept, write back from stage one
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= line_mem[c0];
        end
        if (wr_en)
        begin
            line_mem[s1_col_reg] <= wr_data;
        end
    end

    // the previous write may hit the entry read in the same cycle
    assign fwd_hit  = fwd_valid_reg && (fwd_col_reg == s1_col_reg);
    assign line_old = fwd_hit ? fwd_data_reg : rd_data_reg;

    // new column and shifted row delays
    always_comb
    begin
        col_px[0] = s1_pixel_reg;
        for (int i = 1; i < MAX_KERNEL; i++)
        begin
            col_px[i] = line_old[(i-1)*PIX_W +: PIX_W];
        end
        wr_data[PIX_W-1:0] = s1_pixel_reg;
        for (int i = 1; i < SLOTS; i++)
        begin
            wr_data[i*PIX_W +: PIX_W] = line_old[(i-1)*PIX_W +: PIX_W];
        end
    end

    // raw window columns, newest column from stage one
    always_comb
    begin
        for (int i = 0; i < MAX_KERNEL; i++)
        begin
            win_px[0][i] = col_px[i];
            for (int j = 1; j < MAX_KERNEL; j++)
            begin
                win_px[j][i] = win_reg[j-1][i];
            end
        end
    end

    // column extremes over the kernel rows
    always_comb
    begin
        for (int j = 0; j < MAX_KERNEL; j++)
        begin
            col_acc[j] = ident_px(mode_reg);
            for (int i = 0; i < MAX_KERNEL; i++)
            begin
                if (KSIDE_W'(i) < k_side)
                begin
                    col_acc[j] = pick_px(mode_reg, col_acc[j], win_px[j][i]);
                end
            end
        end
    end

    // window extreme over the kernel columns
    always_comb
    begin
        win_acc = ident_px(mode_reg);
        for (int j = 0; j < MAX_KERNEL; j++)
        begin
            if (KSIDE_W'(j) < k_side)
            begin
                win_acc = pick_px(mode_reg, win_acc, colred_reg[j]);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= c0;
            fwd_col_reg  <= s1_col_reg;
            fwd_data_reg <= wr_data;
            if (s1_valid_reg)
            begin
                for (int j = 0; j < MAX_KERNEL; j++)
                begin
                    colred_reg[j] <= col_acc[j];
                end
                for (int i = 0; i < MAX_KERNEL; i++)
                begin
                    win_reg[0][i] <= col_px[i];
                    for (int j = 1; j < SLOTS; j++)
                    begin
                        win_reg[j][i] <= win_reg[j-1][i];
                    end
                end
            end
            value_reg     <= win_acc;
            frame_end_reg <= s2_flags_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign frame_end = frame_end_reg;

    // checks on the pipeline
    `SWMMF_ASSERT_NXT(a_accept_enters_s1, accept, s1_valid_reg)
    `SWMMF_ASSERT_NXT(a_s1_holds, s1_valid_reg && !pipe_en, s1_valid_reg && $stable(s1_col_reg) && $stable(s1_pixel_reg))
    `SWMMF_ASSERT_NXT(a_s2_holds, s2_valid_reg && !pipe_en, s2_valid_reg && $stable(s2_flags_reg))
    `SWMMF_ASSERT_NXT(a_emit_reaches_out, s2_valid_reg && s2_flags_reg.emit && pipe_en, out_valid_reg && (frame_end_reg == $past(s2_flags_reg.last)))

endmodule
